FILE: rtl/lmie_pkg.sv
// shared constants, codes and store port types of the logic machine instruction executor
package lmie_pkg;

	localparam int REG_COUNT_DEF   = 16;
	localparam int HEAP_WORDS_DEF  = 8192;
	localparam int STACK_WORDS_DEF = 8192;
	localparam int PDL_WORDS_DEF   = 1024;

	localparam logic [7:0] TAG_REF = 8'd1;
	localparam logic [7:0] TAG_STR = 8'd2;

	localparam logic [4:0] FN_PUT_STRUC  = 5'd1;
	localparam logic [4:0] FN_SET_VAR    = 5'd2;
	localparam logic [4:0] FN_SET_VAL    = 5'd3;
	localparam logic [4:0] FN_GET_STRUC  = 5'd4;
	localparam logic [4:0] FN_UNIFY_VAR  = 5'd5;
	localparam logic [4:0] FN_UNIFY_VAL  = 5'd6;
	localparam logic [4:0] FN_PUT_VAR    = 5'd7;
	localparam logic [4:0] FN_PUT_VAL    = 5'd8;
	localparam logic [4:0] FN_GET_VAR    = 5'd9;
	localparam logic [4:0] FN_GET_VAL    = 5'd10;
	localparam logic [4:0] FN_CALL       = 5'd11;
	localparam logic [4:0] FN_PROCEED    = 5'd12;
	localparam logic [4:0] FN_ALLOCATE   = 5'd13;
	localparam logic [4:0] FN_DEALLOCATE = 5'd14;
	localparam logic [4:0] FN_READ_CELL  = 5'd15;
	localparam logic [4:0] FN_DEREF      = 5'd16;

	localparam logic [1:0] MODE_SLOT = 2'd2;

	typedef struct packed {
		logic [31:0] rd_addr;
		logic        wr_en;
		logic [31:0] wr_addr;
		logic [31:0] wr_data;
	} store_req_t;

endpackage

FILE: rtl/logic_machine_instruction_executor.sv
// logic machine instruction executor: sequencer around the tagged cell store
//
//  channel   handshake           payload
//  command   start / busy        func addr_mode var_slot arg_reg functor_word call_target
//                                frame_size instr_addr start_req query_address
//  result    done (one cycle)    next_ip failed finished read_word deref_address
//                                deref_tag deref_value
//  config    cfg_we              cfg_data (code_length)
//
// one item at a time; every store access is a registered read or a write.
// dereference costs one cycle per chain link; unification pops pairs, compares
// functors and pushes argument pairs on the push-down list.
// after reset the store is cleared, one word a cycle, all REG_COUNT + HEAP_WORDS +
// STACK_WORDS + PDL_WORDS words, with busy high.
// results cannot be held off: done is high for exactly one cycle.
module logic_machine_instruction_executor #(
	parameter int REG_COUNT   = lmie_pkg::REG_COUNT_DEF,
	parameter int HEAP_WORDS  = lmie_pkg::HEAP_WORDS_DEF,
	parameter int STACK_WORDS = lmie_pkg::STACK_WORDS_DEF,
	parameter int PDL_WORDS   = lmie_pkg::PDL_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [4:0]  func,
	input  logic [1:0]  addr_mode,
	input  logic [7:0]  var_slot,
	input  logic [7:0]  arg_reg,
	input  logic [31:0] functor_word,
	input  logic signed [24:0] call_target,
	input  logic [7:0]  frame_size,
	input  logic [23:0] instr_addr,
	input  logic        start_req,
	input  logic [23:0] query_address,
	input  logic        cfg_we,
	input  logic [23:0] cfg_data,
	output logic        done,
	output logic [23:0] next_ip,
	output logic        failed,
	output logic        finished,
	output logic [31:0] read_word,
	output logic [23:0] deref_address,
	output logic [7:0]  deref_tag,
	output logic [23:0] deref_value
);
	localparam int PDL_FLOOR   = REG_COUNT + HEAP_WORDS + STACK_WORDS;
	localparam int STORE_DEPTH = PDL_FLOOR + PDL_WORDS;
	localparam int ENV_RESET   = REG_COUNT + HEAP_WORDS;
	localparam int CW          = $clog2(STORE_DEPTH + 1);

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_DEC, S_WR, S_RD, S_RD2, S_GS, S_GS2,
		S_DA1, S_DA2, S_DA3, S_RQ, S_RQ2, S_DQ, S_DR0, S_DR1, S_DR2,
		S_PUSH1, S_PUSH2, S_ULOOP, S_UPOP1, S_UGOT1, S_UPOP2, S_UGOT2,
		S_UF1, S_UF2, S_FIN
	} state_t;

	state_t state_q, ret_q;

	logic [4:0]  func_q;
	logic [1:0]  mode_q;
	logic [7:0]  slot_q, ai_q, fsize_q;
	logic [31:0] fn_q;
	logic [24:0] tgt_q;
	logic [23:0] ip_q, qa_q;

	logic [23:0]   ht_q, sp_q, cont_q, eb_q, et_q, clen_q;
	logic [CW-1:0] pdl_q;
	logic          wm_q;
	logic [7:0]    ltag_q;
	logic [23:0]   lval_q;

	logic [31:0] wa_q [3];
	logic [31:0] wd_q [3];
	logic [1:0]  wlast_q, wi_q;

	logic [23:0] nip_q;
	logic        fail_q, done_q, finished_q;
	logic [31:0] rword_q;
	logic [23:0] daddr_q;

	logic [31:0]   dr_at_q;
	logic [23:0]   dr_val_q;
	logic [CW-1:0] dr_steps_q;

	logic [31:0]   u_x_q, u_y_q, u_d1_q, u_f1_q;
	logic [7:0]    u_t1_q, u_n_q;
	logic [23:0]   u_v1_q, u_v2_q;
	logic [8:0]    u_i_q;
	logic          u_arg_q;
	logic [CW-1:0] u_steps_q;

	lmie_pkg::store_req_t req;
	logic [31:0] rdata;
	logic        clearing;

	logic [31:0] xi, ai, cur_pdl, px, py;
	logic [7:0]  r_tag;
	logic [23:0] r_val;
	logic [CW-1:0] dr_next;
	logic        push_ok;

	lmie_store #(.DEPTH(STORE_DEPTH)) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rdata   (rdata),
		.clearing(clearing)
	);

	assign xi = {24'd0, slot_q} + ((mode_q == lmie_pkg::MODE_SLOT) ?
		({8'd0, eb_q} + 32'd3) : 32'd0);
	assign ai      = {24'd0, ai_q};
	assign cur_pdl = 32'(pdl_q);
	assign r_tag   = rdata[31:24];
	assign r_val   = rdata[23:0];
	assign dr_next = dr_steps_q + 1'b1;
	assign push_ok = pdl_q >= CW'(PDL_FLOOR + 2);
	assign px      = u_arg_q ? ({8'd0, u_v1_q} + 32'(u_i_q)) : u_x_q;
	assign py      = u_arg_q ? ({8'd0, u_v2_q} + 32'(u_i_q)) : u_y_q;

	assign busy          = state_q != S_IDLE;
	assign done          = done_q;
	assign next_ip       = nip_q;
	assign failed        = fail_q;
	assign finished      = finished_q;
	assign read_word     = rword_q;
	assign deref_address = daddr_q;
	assign deref_tag     = ltag_q;
	assign deref_value   = lval_q;

	// store port selection per step
	always_comb begin
		req = '0;
		unique case (state_q)
			S_WR: begin
				req.wr_en   = 1'b1;
				req.wr_addr = wa_q[wi_q];
				req.wr_data = wd_q[wi_q];
			end
			S_RD:  req.rd_addr = wa_q[1];
			S_RD2: begin
				req.wr_en   = 1'b1;
				req.wr_addr = wa_q[0];
				req.wr_data = rdata;
			end
			S_GS:  req.rd_addr = {8'd0, lval_q};
			S_DA1: req.rd_addr = {8'd0, eb_q} + 32'd1;
			S_DA2: req.rd_addr = {8'd0, eb_q};
			S_RQ:  req.rd_addr = {8'd0, qa_q};
			S_DR0: req.rd_addr = dr_at_q;
			S_DR1, S_DR2: req.rd_addr = {8'd0, r_val};
			S_PUSH1: begin
				req.wr_en   = push_ok;
				req.wr_addr = cur_pdl - 32'd1;
				req.wr_data = px;
			end
			S_PUSH2: begin
				req.wr_en   = 1'b1;
				req.wr_addr = cur_pdl - 32'd1;
				req.wr_data = py;
			end
			S_ULOOP, S_UGOT1: req.rd_addr = cur_pdl;
			S_UGOT2: begin
				req.rd_addr = {8'd0, u_v1_q};
				if (u_d1_q != dr_at_q) begin
					if (u_t1_q == lmie_pkg::TAG_REF) begin
						req.wr_en   = 1'b1;
						req.wr_addr = u_d1_q;
						req.wr_data = {lmie_pkg::TAG_REF, dr_at_q[23:0]};
					end else if (ltag_q == lmie_pkg::TAG_REF) begin
						req.wr_en   = 1'b1;
						req.wr_addr = dr_at_q;
						req.wr_data = {lmie_pkg::TAG_REF, u_d1_q[23:0]};
					end
				end
			end
			S_UF1: req.rd_addr = {8'd0, u_v2_q};
			default: req = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			ret_q      <= S_FIN;
			func_q     <= '0;
			mode_q     <= '0;
			slot_q     <= '0;
			ai_q       <= '0;
			fsize_q    <= '0;
			fn_q       <= '0;
			tgt_q      <= '0;
			ip_q       <= '0;
			qa_q       <= '0;
			ht_q       <= 24'(REG_COUNT);
			sp_q       <= 24'(REG_COUNT);
			cont_q     <= '0;
			eb_q       <= 24'(ENV_RESET);
			et_q       <= 24'(ENV_RESET);
			clen_q     <= '0;
			pdl_q      <= CW'(STORE_DEPTH);
			wm_q       <= 1'b0;
			ltag_q     <= '0;
			lval_q     <= '0;
			wa_q       <= '{default: '0};
			wd_q       <= '{default: '0};
			wlast_q    <= '0;
			wi_q       <= '0;
			nip_q      <= '0;
			fail_q     <= 1'b0;
			done_q     <= 1'b0;
			finished_q <= 1'b0;
			rword_q    <= '0;
			daddr_q    <= '0;
			dr_at_q    <= '0;
			dr_val_q   <= '0;
			dr_steps_q <= '0;
			u_x_q      <= '0;
			u_y_q      <= '0;
			u_d1_q     <= '0;
			u_f1_q     <= '0;
			u_t1_q     <= '0;
			u_n_q      <= '0;
			u_v1_q     <= '0;
			u_v2_q     <= '0;
			u_i_q      <= '0;
			u_arg_q    <= 1'b0;
			u_steps_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				clen_q <= cfg_data;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (!clearing) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						func_q  <= func;
						mode_q  <= addr_mode;
						slot_q  <= var_slot;
						ai_q    <= arg_reg;
						fn_q    <= functor_word;
						tgt_q   <= call_target;
						fsize_q <= frame_size;
						ip_q    <= instr_addr;
						qa_q    <= query_address;
						if (start_req) begin
							cont_q <= clen_q;
							pdl_q  <= CW'(STORE_DEPTH);
						end
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					nip_q   <= ip_q;
					fail_q  <= 1'b0;
					rword_q <= '0;
					daddr_q <= '0;
					wi_q    <= '0;
					u_arg_q <= 1'b0;
					u_steps_q <= '0;
					state_q <= S_FIN;
					unique case (func_q)
						lmie_pkg::FN_PUT_STRUC: begin
							wa_q[0] <= {8'd0, ht_q};
							wd_q[0] <= {lmie_pkg::TAG_STR, ht_q + 24'd1};
							wa_q[1] <= {8'd0, ht_q} + 32'd1;
							wd_q[1] <= fn_q;
							wa_q[2] <= xi;
							wd_q[2] <= {lmie_pkg::TAG_STR, ht_q + 24'd1};
							wlast_q <= 2'd2;
							ht_q    <= ht_q + 24'd2;
							nip_q   <= ip_q + 24'd7;
							state_q <= S_WR;
						end
						lmie_pkg::FN_SET_VAR, lmie_pkg::FN_PUT_VAR: begin
							wa_q[0] <= {8'd0, ht_q};
							wd_q[0] <= {lmie_pkg::TAG_REF, ht_q};
							wa_q[1] <= xi;
							wd_q[1] <= {lmie_pkg::TAG_REF, ht_q};
							wa_q[2] <= ai;
							wd_q[2] <= {lmie_pkg::TAG_REF, ht_q};
							wlast_q <= (func_q == lmie_pkg::FN_PUT_VAR) ? 2'd2 : 2'd1;
							ht_q    <= ht_q + 24'd1;
							nip_q   <= ip_q + ((func_q == lmie_pkg::FN_PUT_VAR) ?
								24'd4 : 24'd3);
							state_q <= S_WR;
						end
						lmie_pkg::FN_SET_VAL: begin
							wa_q[1] <= xi;
							wa_q[0] <= {8'd0, ht_q};
							ht_q    <= ht_q + 24'd1;
							nip_q   <= ip_q + 24'd3;
							state_q <= S_RD;
						end
						lmie_pkg::FN_GET_STRUC: begin
							nip_q   <= ip_q + 24'd7;
							dr_at_q <= xi;
							ret_q   <= S_GS;
							state_q <= S_DR0;
						end
						lmie_pkg::FN_UNIFY_VAR: begin
							nip_q <= ip_q + 24'd3;
							sp_q  <= sp_q + 24'd1;
							if (wm_q) begin
								wa_q[0] <= {8'd0, ht_q};
								wd_q[0] <= {lmie_pkg::TAG_REF, ht_q};
								wa_q[1] <= xi;
								wd_q[1] <= {lmie_pkg::TAG_REF, ht_q};
								wlast_q <= 2'd1;
								ht_q    <= ht_q + 24'd1;
								state_q <= S_WR;
							end else begin
								wa_q[1] <= {8'd0, sp_q};
								wa_q[0] <= xi;
								state_q <= S_RD;
							end
						end
						lmie_pkg::FN_UNIFY_VAL: begin
							nip_q <= ip_q + 24'd3;
							sp_q  <= sp_q + 24'd1;
							if (wm_q) begin
								wa_q[1] <= xi;
								wa_q[0] <= {8'd0, ht_q};
								ht_q    <= ht_q + 24'd1;
								state_q <= S_RD;
							end else begin
								u_x_q   <= xi;
								u_y_q   <= {8'd0, sp_q};
								state_q <= S_PUSH1;
							end
						end
						lmie_pkg::FN_PUT_VAL: begin
							wa_q[1] <= xi;
							wa_q[0] <= ai;
							nip_q   <= ip_q + 24'd4;
							state_q <= S_RD;
						end
						lmie_pkg::FN_GET_VAR: begin
							wa_q[1] <= ai;
							wa_q[0] <= xi;
							nip_q   <= ip_q + 24'd4;
							state_q <= S_RD;
						end
						lmie_pkg::FN_GET_VAL: begin
							nip_q   <= ip_q + 24'd4;
							u_x_q   <= xi;
							u_y_q   <= ai;
							state_q <= S_PUSH1;
						end
						lmie_pkg::FN_CALL: begin
							if (tgt_q[24]) begin
								fail_q <= 1'b1;
							end else begin
								cont_q <= ip_q + 24'd5;
								nip_q  <= tgt_q[23:0];
							end
						end
						lmie_pkg::FN_PROCEED: nip_q <= cont_q;
						lmie_pkg::FN_ALLOCATE: begin
							wa_q[0] <= {8'd0, et_q};
							wd_q[0] <= {8'd0, eb_q};
							wa_q[1] <= {8'd0, et_q} + 32'd1;
							wd_q[1] <= {8'd0, cont_q};
							wa_q[2] <= {8'd0, et_q} + 32'd2;
							wd_q[2] <= {24'd0, fsize_q};
							wlast_q <= 2'd2;
							eb_q    <= et_q;
							et_q    <= et_q + {16'd0, fsize_q} + 24'd3;
							nip_q   <= ip_q + 24'd2;
							state_q <= S_WR;
						end
						lmie_pkg::FN_DEALLOCATE: state_q <= S_DA1;
						lmie_pkg::FN_READ_CELL:  state_q <= S_RQ;
						lmie_pkg::FN_DEREF: begin
							dr_at_q <= {8'd0, qa_q};
							ret_q   <= S_DQ;
							state_q <= S_DR0;
						end
						default: fail_q <= 1'b1;
					endcase
				end
				S_WR: begin
					if (wi_q == wlast_q) begin
						state_q <= S_FIN;
					end
					wi_q <= wi_q + 2'd1;
				end
				S_RD:  state_q <= S_RD2;
				S_RD2: state_q <= S_FIN;
				S_GS: begin
					if (ltag_q == lmie_pkg::TAG_REF) begin
						wa_q[0] <= {8'd0, ht_q};
						wd_q[0] <= {lmie_pkg::TAG_STR, ht_q + 24'd1};
						wa_q[1] <= {8'd0, ht_q} + 32'd1;
						wd_q[1] <= fn_q;
						wa_q[2] <= dr_at_q;
						wd_q[2] <= {lmie_pkg::TAG_REF, ht_q};
						wlast_q <= 2'd2;
						ht_q    <= ht_q + 24'd2;
						wm_q    <= 1'b1;
						state_q <= S_WR;
					end else if (ltag_q == lmie_pkg::TAG_STR) begin
						state_q <= S_GS2;
					end else begin
						fail_q  <= 1'b1;
						state_q <= S_FIN;
					end
				end
				S_GS2: begin
					if (rdata == fn_q) begin
						sp_q <= lval_q + 24'd1;
						wm_q <= 1'b0;
					end else begin
						fail_q <= 1'b1;
					end
					state_q <= S_FIN;
				end
				S_DA1: state_q <= S_DA2;
				S_DA2: begin
					nip_q   <= r_val;
					state_q <= S_DA3;
				end
				S_DA3: begin
					et_q    <= eb_q;
					eb_q    <= r_val;
					state_q <= S_FIN;
				end
				S_RQ:  state_q <= S_RQ2;
				S_RQ2: begin
					rword_q <= rdata;
					state_q <= S_FIN;
				end
				S_DQ: begin
					daddr_q <= dr_at_q[23:0];
					state_q <= S_FIN;
				end
				S_DR0: state_q <= S_DR1;
				S_DR1: begin
					if (r_tag == lmie_pkg::TAG_REF) begin
						dr_at_q    <= {8'd0, r_val};
						dr_val_q   <= r_val;
						dr_steps_q <= '0;
						state_q    <= S_DR2;
					end else begin
						ltag_q  <= r_tag;
						lval_q  <= r_val;
						state_q <= ret_q;
					end
				end
				S_DR2: begin
					if (r_val == dr_val_q) begin
						// self reference ends the chain
						ltag_q  <= r_tag;
						lval_q  <= dr_val_q;
						state_q <= ret_q;
					end else if (r_tag == lmie_pkg::TAG_REF &&
						dr_next < CW'(STORE_DEPTH)) begin
						dr_at_q    <= {8'd0, r_val};
						dr_val_q   <= r_val;
						dr_steps_q <= dr_next;
					end else begin
						ltag_q  <= r_tag;
						lval_q  <= r_val;
						state_q <= ret_q;
					end
				end
				S_PUSH1: begin
					if (push_ok) begin
						pdl_q   <= pdl_q - 1'b1;
						state_q <= S_PUSH2;
					end else begin
						fail_q  <= 1'b1;
						state_q <= S_FIN;
					end
				end
				S_PUSH2: begin
					pdl_q <= pdl_q - 1'b1;
					if (u_arg_q && u_i_q < {1'b0, u_n_q}) begin
						u_i_q   <= u_i_q + 9'd1;
						state_q <= S_PUSH1;
					end else begin
						state_q <= S_ULOOP;
					end
				end
				S_ULOOP: begin
					if (pdl_q >= CW'(STORE_DEPTH)) begin
						state_q <= S_FIN;
					end else if (u_steps_q >= CW'(STORE_DEPTH)) begin
						fail_q  <= 1'b1;
						state_q <= S_FIN;
					end else begin
						u_steps_q <= u_steps_q + 1'b1;
						pdl_q     <= pdl_q + 1'b1;
						state_q   <= S_UPOP1;
					end
				end
				S_UPOP1: begin
					dr_at_q <= rdata;
					ret_q   <= S_UGOT1;
					state_q <= S_DR0;
				end
				S_UGOT1: begin
					u_d1_q <= dr_at_q;
					u_t1_q <= ltag_q;
					u_v1_q <= lval_q;
					if (pdl_q >= CW'(STORE_DEPTH)) begin
						// empty list pops as zero
						dr_at_q <= '0;
						ret_q   <= S_UGOT2;
						state_q <= S_DR0;
					end else begin
						pdl_q   <= pdl_q + 1'b1;
						state_q <= S_UPOP2;
					end
				end
				S_UPOP2: begin
					dr_at_q <= rdata;
					ret_q   <= S_UGOT2;
					state_q <= S_DR0;
				end
				S_UGOT2: begin
					u_v2_q <= lval_q;
					if (u_d1_q == dr_at_q || u_t1_q == lmie_pkg::TAG_REF ||
						ltag_q == lmie_pkg::TAG_REF) begin
						state_q <= S_ULOOP;
					end else begin
						state_q <= S_UF1;
					end
				end
				S_UF1: begin
					u_f1_q  <= rdata;
					state_q <= S_UF2;
				end
				S_UF2: begin
					if (rdata != u_f1_q) begin
						fail_q  <= 1'b1;
						state_q <= S_FIN;
					end else if (u_f1_q[7:0] == 8'd0) begin
						state_q <= S_ULOOP;
					end else begin
						u_n_q   <= u_f1_q[7:0];
						u_i_q   <= 9'd1;
						u_arg_q <= 1'b1;
						state_q <= S_PUSH1;
					end
				end
				S_FIN: begin
					done_q     <= 1'b1;
					finished_q <= nip_q >= clen_q;
					state_q    <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without work in progress");

	a_no_done_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !done)
		else $error("result strobe right after a transfer");

	a_pdl_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		pdl_q <= CW'(STORE_DEPTH) && pdl_q >= CW'(PDL_FLOOR))
		else $error("push-down pointer out of its region");

	a_write_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.wr_en |-> (busy && !clearing))
		else $error("store write while idle or clearing");

endmodule

FILE: rtl/lmie_store.sv
// tagged cell store: one write port, one registered read port, clearing pass after reset
module lmie_store #(
	parameter int DEPTH = 17424
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lmie_pkg::store_req_t req,
	output logic [31:0]         rdata,
	output logic                clearing
);
	localparam int AW = $clog2(DEPTH);

	logic [31:0]   mem [DEPTH];
	logic [AW-1:0] clr_q;
	logic          clearing_q;
	logic [31:0]   rdata_q;
	logic          wr_hit;
	logic          rd_hit;

	assign wr_hit   = req.wr_en && (req.wr_addr < 32'(DEPTH));
	assign rd_hit   = req.rd_addr < 32'(DEPTH);
	assign clearing = clearing_q;
	assign rdata    = rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			if (clr_q == AW'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_q] <= '0;
		end else if (wr_hit) begin
			mem[req.wr_addr[AW-1:0]] <= req.wr_data;
		end
		// out of range reads give zero
		rdata_q <= rd_hit ? mem[req.rd_addr[AW-1:0]] : 32'd0;
	end

endmodule
